// ===== hw/rtl/wsf_pkg.sv =====
package wsf_pkg;

	localparam int FFT_LEN    = 64;
	localparam int WINDOW_LEN = 64;
	localparam int HOP_LEN    = 32;
	localparam int NBINS      = FFT_LEN / 2 + 1;
	localparam int BUILD_LEN  = (FFT_LEN > WINDOW_LEN) ? FFT_LEN : WINDOW_LEN;

	localparam int ADDR_W  = $clog2(FFT_LEN);
	localparam int WIN_W   = $clog2(WINDOW_LEN);
	localparam int BUILD_W = $clog2(BUILD_LEN);
	localparam int HOP_W   = $clog2(HOP_LEN + 1);
	localparam int ACC_W   = 48 + ADDR_W;

	localparam logic [16:0] WIN_ONE = 17'd32768;

	localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
	localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [63:0] BIN_MAX     = 64'sd8388607;
	localparam logic signed [63:0] BIN_MIN     = -64'sd8388608;

	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} tw_t;

	typedef logic signed [31:0] tw_tab_t [FFT_LEN];
	typedef logic [16:0] win_tab_t [WINDOW_LEN];

	typedef struct packed {
		logic               push;
		logic               build;
		logic [BUILD_W-1:0] pos;
	} wsf_hist_ctl_t;

	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic signed [15:0] data;
	} wsf_wr_t;

	typedef struct packed {
		logic              clear;
		logic              issue;
		logic [ADDR_W-1:0] n;
		logic [ADDR_W-1:0] idx;
	} wsf_mac_ctl_t;

	// taylor series on the reduced angle, then quadrant fold
	function automatic tw_t trig_core(input logic [63:0] theta, input logic [1:0] quad);
		logic [63:0] x2;
		logic [63:0] tc;
		logic [63:0] ts;
		logic signed [63:0] c;
		logic signed [63:0] s;
		tw_t r;
		x2 = (theta * theta) >> 30;
		tc = 64'(ONE_Q30);
		ts = theta;
		c  = ONE_Q30;
		s  = signed'(theta);
		for (int k = 1; k <= 8; k++) begin
			tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if ((k % 2) == 1) begin
				c = c - signed'(tc);
				s = s - signed'(ts);
			end else begin
				c = c + signed'(tc);
				s = s + signed'(ts);
			end
		end
		case (quad)
			2'd0: begin
				r.c = 32'(c);
				r.s = 32'(s);
			end
			2'd1: begin
				r.c = 32'(-s);
				r.s = 32'(c);
			end
			2'd2: begin
				r.c = 32'(-c);
				r.s = 32'(-s);
			end
			default: begin
				r.c = 32'(s);
				r.s = 32'(-c);
			end
		endcase
		return r;
	endfunction

	function automatic tw_t trig_fft(input int a);
		logic [63:0] r;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] theta;
		r     = 64'(4 * a);
		quad  = r / FFT_LEN;
		rem   = r % FFT_LEN;
		theta = (rem * HALF_PI_Q30) / FFT_LEN;
		return trig_core(theta, quad[1:0]);
	endfunction

	function automatic tw_t trig_win(input int a);
		logic [63:0] r;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] theta;
		r     = 64'(4 * a);
		quad  = r / WINDOW_LEN;
		rem   = r % WINDOW_LEN;
		theta = (rem * HALF_PI_Q30) / WINDOW_LEN;
		return trig_core(theta, quad[1:0]);
	endfunction

	function automatic tw_tab_t gen_cos_tab();
		tw_tab_t r;
		tw_t t;
		for (int n = 0; n < FFT_LEN; n++) begin
			t    = trig_fft(n);
			r[n] = t.c;
		end
		return r;
	endfunction

	function automatic tw_tab_t gen_sin_tab();
		tw_tab_t r;
		tw_t t;
		for (int n = 0; n < FFT_LEN; n++) begin
			t    = trig_fft(n);
			r[n] = t.s;
		end
		return r;
	endfunction

	function automatic win_tab_t gen_hann_tab();
		win_tab_t r;
		tw_t t;
		logic signed [63:0] d;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			t = trig_win(k);
			d = ONE_Q30 - 64'(t.c);
			if (d < 0) begin
				d = 64'sd0;
			end
			r[k] = 17'((d + 64'sd32768) >>> 16);
		end
		return r;
	endfunction

	localparam tw_tab_t  COS_TAB  = gen_cos_tab();
	localparam tw_tab_t  SIN_TAB  = gen_sin_tab();
	localparam win_tab_t HANN_TAB = gen_hann_tab();

endpackage

// ===== hw/rtl/wsf_history.sv =====
module wsf_history import wsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wsf_hist_ctl_t      ctl,
	input  logic signed [15:0] sample,
	input  logic               window_mode,
	output wsf_wr_t            wr
);

	logic signed [15:0] hist_q [WINDOW_LEN];
	logic               in_win;
	logic               in_fft;
	logic [16:0]        w;
	logic signed [33:0] p_s1;
	logic signed [33:0] rnd;
	logic               wr_s1;
	logic               zero_s1;
	logic [ADDR_W-1:0]  addr_s1;

	assign in_win = {1'b0, ctl.pos} < (BUILD_W + 1)'(WINDOW_LEN);
	assign in_fft = {1'b0, ctl.pos} < (BUILD_W + 1)'(FFT_LEN);
	assign w = !in_win ? 17'd0 : (window_mode ? HANN_TAB[ctl.pos[WIN_W-1:0]] : WIN_ONE);

	// shift in on push, rotate once per window entry while building a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				hist_q[k] <= '0;
			end
		end else if (ctl.push) begin
			for (int k = 0; k < WINDOW_LEN - 1; k++) begin
				hist_q[k] <= hist_q[k+1];
			end
			hist_q[WINDOW_LEN-1] <= sample;
		end else if (ctl.build && in_win) begin
			for (int k = 0; k < WINDOW_LEN - 1; k++) begin
				hist_q[k] <= hist_q[k+1];
			end
			hist_q[WINDOW_LEN-1] <= hist_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= ctl.build && in_fft;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= hist_q[0] * $signed({1'b0, w});
		zero_s1 <= !in_win;
		addr_s1 <= ctl.pos[ADDR_W-1:0];
	end

	assign rnd     = (p_s1 + 34'sd16384) >>> 15;
	assign wr.wr   = wr_s1;
	assign wr.addr = addr_s1;
	assign wr.data = zero_s1 ? 16'sd0 : rnd[15:0];

endmodule

// ===== hw/rtl/wsf_mac.sv =====
module wsf_mac import wsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wsf_wr_t            wr,
	input  wsf_mac_ctl_t       ctl,
	output logic               busy,
	output logic signed [23:0] bin_re,
	output logic signed [23:0] bin_im
);

	logic signed [15:0]      mem [FFT_LEN];
	logic signed [15:0]      rd_q;
	logic signed [31:0]      cos_s1;
	logic signed [31:0]      sin_s1;
	logic                    v_s1;
	logic signed [47:0]      pre_s2;
	logic signed [47:0]      pim_s2;
	logic                    v_s2;
	logic signed [ACC_W-1:0] acc_re_q;
	logic signed [ACC_W-1:0] acc_im_q;
	logic signed [63:0]      q_re;
	logic signed [63:0]      q_im;

	always_ff @(posedge clk) begin
		if (wr.wr) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q   <= mem[ctl.n];
		cos_s1 <= COS_TAB[ctl.idx];
		sin_s1 <= SIN_TAB[ctl.idx];
		pre_s2 <= rd_q * cos_s1;
		pim_s2 <= rd_q * sin_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			if (ctl.clear) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else if (v_s2) begin
				acc_re_q <= acc_re_q + ACC_W'(pre_s2);
				acc_im_q <= acc_im_q - ACC_W'(pim_s2);
			end
		end
	end

	assign busy = v_s1 || v_s2;

	// round half up, then clamp to 24 bits
	assign q_re = (64'(acc_re_q) + 64'sd536870912) >>> 30;
	assign q_im = (64'(acc_im_q) + 64'sd536870912) >>> 30;

	always_comb begin
		if (q_re > BIN_MAX) begin
			bin_re = 24'(BIN_MAX);
		end else if (q_re < BIN_MIN) begin
			bin_re = 24'(BIN_MIN);
		end else begin
			bin_re = q_re[23:0];
		end
		if (q_im > BIN_MAX) begin
			bin_im = 24'(BIN_MAX);
		end else if (q_im < BIN_MIN) begin
			bin_im = 24'(BIN_MIN);
		end else begin
			bin_im = q_im[23:0];
		end
	end

endmodule

// ===== hw/rtl/windowed_stft_frame.sv =====
// samples that do not close a hop are accepted and the input stays ready
// a hop-closing sample starts a frame: the history is windowed into the sample
// memory, then each bin is accumulated on the single multiply-accumulate unit
// and offered on the output; no new sample is accepted until the last bin is taken
// reset: history all zero, hop count zero, window_mode Hann, no bin pending
module windowed_stft_frame import wsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // bin_index, bin_real, bin_imag
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BUILD = 3'd1;
	localparam logic [2:0] ST_DFT   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic REG_WINDOW_MODE = 1'b0;

	logic [2:0]         state_q;
	logic [HOP_W-1:0]   hop_q;
	logic [BUILD_W-1:0] cnt_q;
	logic [ADDR_W-1:0]  n_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [5:0]         m_q;
	logic               mode_q;
	logic [5:0]         bin_idx_q;
	logic signed [23:0] bin_re_q;
	logic signed [23:0] bin_im_q;
	logic               last_q;
	logic               in_hs;
	logic               out_hs;
	logic               busy;
	logic signed [23:0] bin_re;
	logic signed [23:0] bin_im;
	logic [ADDR_W:0]    idx_sum;
	wsf_hist_ctl_t      hctl;
	wsf_mac_ctl_t       mctl;
	wsf_wr_t            wr;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW_MODE) ? {31'b0, mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_hs  = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_hs = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {2'b0, bin_im_q, bin_re_q, bin_idx_q};
	assign m_axis_tlast = last_q;

	assign idx_sum = {1'b0, idx_q} + (ADDR_W + 1)'(m_q);

	assign hctl.push  = in_hs;
	assign hctl.build = (state_q == ST_BUILD);
	assign hctl.pos   = cnt_q;

	assign mctl.clear = (state_q == ST_BUILD && cnt_q == BUILD_W'(BUILD_LEN - 1))
		|| (out_hs && !last_q);
	assign mctl.issue = (state_q == ST_DFT);
	assign mctl.n     = n_q;
	assign mctl.idx   = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hop_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			m_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_hs) begin
						if (hop_q == HOP_W'(HOP_LEN - 1)) begin
							hop_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_BUILD;
						end else begin
							hop_q <= hop_q + 1'b1;
						end
					end
				end
				ST_BUILD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BUILD_W'(BUILD_LEN - 1)) begin
						n_q     <= '0;
						idx_q   <= '0;
						m_q     <= '0;
						state_q <= ST_DFT;
					end
				end
				ST_DFT: begin
					if (n_q == ADDR_W'(FFT_LEN - 1)) begin
						n_q     <= '0;
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						n_q <= n_q + 1'b1;
						if (idx_sum >= (ADDR_W + 1)'(FFT_LEN)) begin
							idx_q <= ADDR_W'(idx_sum - (ADDR_W + 1)'(FFT_LEN));
						end else begin
							idx_q <= idx_sum[ADDR_W-1:0];
						end
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_hs) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							m_q     <= m_q + 1'b1;
							state_q <= ST_DFT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (state_q == ST_DRAIN && !busy) begin
			last_q <= (m_q == 6'(NBINS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && !busy) begin
			bin_idx_q <= m_q;
			bin_re_q  <= bin_re;
			bin_im_q  <= bin_im;
		end
	end

	wsf_history u_history (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (hctl),
		.sample      (signed'(s_axis_tdata)),
		.window_mode (mode_q),
		.wr          (wr)
	);

	wsf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.ctl    (mctl),
		.busy   (busy),
		.bin_re (bin_re),
		.bin_im (bin_im)
	);

	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while a bin is pending");

	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == 6'(NBINS - 1)))
		else $error("last flag on wrong bin");

	a_next_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!m_axis_tvalid && !s_axis_tready))
		else $error("frame ended before last bin");

	a_no_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !busy)
		else $error("mac busy while idle");

endmodule
